// File: design/mf5_pkg.sv
// shared constants and types for the 5x5 median filter
`default_nettype none
package mf5_pkg;

    // configuration port
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // item kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

    localparam int MIN_SIZE    = 5;
    localparam int COUNT_W     = 23;
    localparam int ROW_W       = 12;
    localparam int WIN         = 5;
    localparam int WIN_CELLS   = 25;
    localparam int RANK_W      = 5;
    localparam int MEDIAN_RANK = 12;

endpackage
`default_nettype wire

// File: design/median_filter_5x5_core.sv
// 5x5 median filter over a raster pixel stream, top level
`default_nettype none
// Takes one pixel item per clock in raster order and returns each pixel
// 2*width+2 items later: inner pixels (two or more away from every edge) as
// the median of their 5x5 neighborhood, border pixels unchanged. After the
// last pixel of a frame, send 2*width+2 flush items to drain the tail; the
// last result carries m_frame_last. Items with no result (the first
// 2*width+2 of a frame) produce nothing on the m_ side. Throughput is one
// item per clock unless s_ready is held low by a full output register or
// the clearing pass. An item passes three register stages (line store read,
// window shift and store write, median and output register) before the
// result it completes is on m_valid. After reset the line store is cleared
// one column per cycle while s_ready stays low; configuration writes are taken meanwhile.
// Width is clamped to 5..MAX_WIDTH and height to at least 5.
module median_filter_5x5_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire [mf5_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [mf5_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_req_type,
    input  wire [PIXEL_BITS-1:0]             s_pixel_in,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [PIXEL_BITS-1:0]            m_pixel_out,
    output logic                             m_frame_last
);
    import mf5_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int DLY_W  = WID_W + 2;
    localparam int WORD_W = 4 * PIXEL_BITS;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    // configuration
    logic [CFG_WIDTH_W-1:0]  width_cfg_reg;
    logic [CFG_HEIGHT_W-1:0] height_cfg_reg;

    // raster position state
    logic [COL_W-1:0]   in_col_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COUNT_W-1:0] item_count_reg;

    // line store clear after reset
    logic             clr_reg;
    logic [COL_W-1:0] clr_addr_reg;

    // line store: one word per column, four rows packed
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];
    logic [WORD_W-1:0] rd1_mem_reg, rd2_mem_reg, byp_data_reg;
    logic              byp1_reg, byp2_reg;

    // stage 1: column fetched
    logic             v1_reg;
    pix_t             pix1_reg;
    logic [COL_W-1:0] ic1_reg, oc1_reg;
    logic             emit1_reg, inner1_reg, last1_reg;

    // stage 2: window loaded
    logic v2_reg, emit2_reg, inner2_reg, last2_reg;
    pix_t pass2_reg;
    pix_t win_reg [WIN][WIN];

    // output register
    logic m_valid_reg, m_last_reg;
    pix_t m_pixel_reg;

    // combinational
    logic [WID_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [DLY_W-1:0]  delay;
    logic [COL_W-1:0]  ic_eff, oc_eff, ic_nxt;
    logic [WID_W:0]    ic_plus, oc_plus;
    logic [ROW_W:0]    row_plus1, row_plus2;
    logic              emit, inner, last, accept, adv, out_free;
    pix_t              pix_in;
    logic              mem_we;
    logic [COL_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata, col1, col2;
    pix_t              med;

    // effective sizes
    always_comb begin
        if (width_cfg_reg < CFG_WIDTH_W'(MIN_SIZE)) begin
            eff_w = WID_W'(MIN_SIZE);
        end else if (32'(width_cfg_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(width_cfg_reg);
        end
        eff_h = (height_cfg_reg < CFG_HEIGHT_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE)
                                                          : height_cfg_reg;
        delay = (DLY_W'(eff_w) << 1) + DLY_W'(2);
    end

    // position of this item and of its result
    always_comb begin
        ic_eff    = (WID_W'(in_col_reg) >= eff_w) ? '0 : in_col_reg;
        oc_eff    = (WID_W'(out_col_reg) >= eff_w) ? '0 : out_col_reg;
        ic_plus   = (WID_W + 1)'(ic_eff) + (WID_W + 1)'(1);
        oc_plus   = (WID_W + 1)'(oc_eff) + (WID_W + 1)'(1);
        ic_nxt    = (ic_plus >= (WID_W + 1)'(eff_w)) ? '0 : COL_W'(ic_plus);
        row_plus1 = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(1);
        row_plus2 = (ROW_W + 1)'(out_row_reg) + (ROW_W + 1)'(2);
        emit      = 32'(item_count_reg) >= 32'(delay);
        inner     = (out_row_reg >= ROW_W'(2)) && (row_plus2 < (ROW_W + 1)'(eff_h)) &&
                    (oc_eff >= COL_W'(2)) &&
                    ((WID_W + 1)'(oc_eff) + (WID_W + 1)'(2) < (WID_W + 1)'(eff_w));
        last      = (row_plus1 >= (ROW_W + 1)'(eff_h)) && (oc_plus == (WID_W + 1)'(eff_w));
        pix_in    = (s_req_type == REQ_FLUSH) ? '0 : s_pixel_in;
    end

    // flow control: stage 2 drains unless it holds a result and output is full
    assign out_free = !m_valid_reg || m_ready;
    assign adv      = !v2_reg || !emit2_reg || out_free;
    assign s_ready  = !clr_reg && (!v1_reg || adv);
    assign accept   = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wr_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wr_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // raster counters, advanced per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            item_count_reg <= '0;
        end else if (accept) begin
            if (emit && last) begin
                // frame done, next item starts a new frame
                in_col_reg     <= '0;
                out_col_reg    <= '0;
                out_row_reg    <= '0;
                item_count_reg <= '0;
            end else begin
                in_col_reg <= ic_nxt;
                if (emit) begin
                    if (oc_plus >= (WID_W + 1)'(eff_w)) begin
                        out_col_reg <= '0;
                        out_row_reg <= row_plus1[ROW_W-1:0];
                    end else begin
                        out_col_reg <= COL_W'(oc_plus);
                    end
                end else begin
                    out_col_reg <= oc_eff;
                end
                if (item_count_reg != '1) begin
                    item_count_reg <= item_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    // clearing pass over the line store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_reg) begin
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_reg <= 1'b0;
            end
        end
    end

    // line store write: column shifts down one row, new pixel on row 0
    assign mem_we    = clr_reg || (v1_reg && adv);
    assign mem_waddr = clr_reg ? clr_addr_reg : ic1_reg;
    assign mem_wdata = clr_reg ? '0 : {col1[3*PIXEL_BITS-1:0], pix1_reg};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd1_mem_reg <= line_mem[ic_eff];
            rd2_mem_reg <= line_mem[oc_eff];
        end
    end

    // forward a write landing in the same cycle as the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp1_reg <= 1'b0;
            byp2_reg <= 1'b0;
        end else if (accept) begin
            byp1_reg <= mem_we && (mem_waddr == ic_eff);
            byp2_reg <= mem_we && (mem_waddr == oc_eff);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byp_data_reg <= mem_wdata;
        end
    end

    assign col1 = byp1_reg ? byp_data_reg : rd1_mem_reg;
    assign col2 = byp2_reg ? byp_data_reg : rd2_mem_reg;

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (!v1_reg || adv) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg   <= pix_in;
            ic1_reg    <= ic_eff;
            oc1_reg    <= oc_eff;
            emit1_reg  <= emit;
            inner1_reg <= inner;
            last1_reg  <= last;
        end
    end

    // stage 2 and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (adv) begin
            v2_reg <= v1_reg;
            if (v1_reg) begin
                for (int r = 0; r < WIN; r++) begin
                    for (int c = 0; c < WIN - 1; c++) begin
                        win_reg[r][c] <= win_reg[r][c+1];
                    end
                end
                win_reg[0][4] <= col1[3*PIXEL_BITS +: PIXEL_BITS];
                win_reg[1][4] <= col1[2*PIXEL_BITS +: PIXEL_BITS];
                win_reg[2][4] <= col1[PIXEL_BITS +: PIXEL_BITS];
                win_reg[3][4] <= col1[0 +: PIXEL_BITS];
                win_reg[4][4] <= pix1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && v1_reg) begin
            emit2_reg  <= emit1_reg;
            inner2_reg <= inner1_reg;
            last2_reg  <= last1_reg;
            // row 2 of the result column after this item's update
            pass2_reg  <= (oc1_reg == ic1_reg) ? col1[PIXEL_BITS +: PIXEL_BITS]
                                               : col2[2*PIXEL_BITS +: PIXEL_BITS];
        end
    end

    // median by rank counting: ties broken by position
    always_comb begin
        logic [RANK_W-1:0] rank [WIN_CELLS];
        pix_t              cells [WIN_CELLS];
        med = '0;
        for (int i = 0; i < WIN_CELLS; i++) begin
            cells[i] = win_reg[i / WIN][i % WIN];
        end
        for (int i = 0; i < WIN_CELLS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WIN_CELLS; j++) begin
                if ((cells[j] < cells[i]) || ((cells[j] == cells[i]) && (j < i))) begin
                    rank[i] = rank[i] + RANK_W'(1);
                end
            end
        end
        for (int i = 0; i < WIN_CELLS; i++) begin
            if (rank[i] == RANK_W'(MEDIAN_RANK)) begin
                med = med | cells[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (v2_reg && emit2_reg && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && emit2_reg && out_free) begin
            m_pixel_reg <= inner2_reg ? med : pass2_reg;
            m_last_reg  <= last2_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

endmodule
`default_nettype wire

// File: sim/median_filter_5x5_core_tb.sv
// self-checking testbench for the 5x5 median filter core
`default_nettype none
module median_filter_5x5_core_tb;
    import mf5_pkg::*;

    localparam int LS_W      = 1024;
    localparam int SETTLE    = 8;     // cycles the core may still be busy after its last result
    localparam int STALL_MAX = 4000;  // covers the line store clearing pass after reset
    localparam int RAND_ITEMS = 1750;

    typedef struct packed {
        logic       kind;
        logic [7:0] pix;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] pix;
        logic       last;
    } filtered_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = REQ_PIXEL;
    logic [7:0] s_pixel_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_pixel_out;
    logic m_frame_last;

    median_filter_5x5_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_pixel_in(s_pixel_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_out(m_pixel_out), .m_frame_last(m_frame_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // pixels waiting to be sent, filtered pixels still to come back
    pixel_item_t pixel_fifo[$];
    filtered_t   filtered_fifo[$];
    int errors = 0;
    int items_taken = 0;
    int stall_cycles = 0;

    // predictor state, mirrors the core
    int unsigned cfg_w = WIDTH_RESET;
    int unsigned cfg_h = HEIGHT_RESET;
    logic [7:0] line_rows [0:4*LS_W-1];
    logic [7:0] window [0:4][0:4];
    int unsigned frame_count = 0;
    int unsigned row_out = 0;
    int unsigned col_out = 0;
    int unsigned col_in = 0;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (item %0d)", what, got, want, items_taken);
        errors++;
    endtask

    function automatic logic [7:0] window_median();
        logic [7:0] vals[$];
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                vals.push_back(window[r][c]);
        vals.sort();
        return vals[MEDIAN_RANK];
    endfunction

    // advance the predictor by one accepted item
    task automatic filter_step(pixel_item_t it);
        int unsigned w, h, lag;
        logic [7:0] px;
        logic [7:0] val;
        logic inner, last;
        filtered_t res;
        w = (cfg_w < MIN_SIZE) ? MIN_SIZE : (cfg_w > LS_W ? LS_W : cfg_w);
        h = (cfg_h < MIN_SIZE) ? MIN_SIZE : cfg_h;
        px = (it.kind == REQ_FLUSH) ? 8'd0 : it.pix;
        lag = 2 * w + 2;
        if (col_in >= w) col_in = 0;
        if (col_out >= w) col_out = 0;
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 4; c++)
                window[r][c] = window[r][c+1];
        window[0][4] = line_rows[3*LS_W + col_in];
        window[1][4] = line_rows[2*LS_W + col_in];
        window[2][4] = line_rows[LS_W + col_in];
        window[3][4] = line_rows[col_in];
        window[4][4] = px;
        for (int k = 3; k > 0; k--)
            line_rows[k*LS_W + col_in] = line_rows[(k-1)*LS_W + col_in];
        line_rows[col_in] = px;
        col_in = (col_in + 1 >= w) ? 0 : col_in + 1;
        if (frame_count >= lag) begin
            inner = row_out >= 2 && row_out + 2 < h && col_out >= 2 && col_out + 2 < w;
            val = inner ? window_median() : line_rows[2*LS_W + col_out];
            last = (row_out + 1 >= h) && (col_out + 1 == w);
            res.pix = val;
            res.last = last;
            filtered_fifo.push_back(res);
            if (last) begin
                frame_count = 0;
                row_out = 0;
                col_out = 0;
                col_in = 0;
                return;
            end
            col_out++;
            if (col_out >= w) begin
                col_out = 0;
                row_out = (row_out + 1) & 12'hFFF;
            end
        end
        if (frame_count < 23'h7FFFFF) frame_count++;
    endtask

    // idle pattern: sender 29 / receiver 77, then swapped, then no idling
    function automatic int send_idle_pct();
        return items_taken < 700 ? 29 : (items_taken < 1400 ? 77 : 0);
    endfunction

    function automatic int recv_idle_pct();
        return items_taken < 700 ? 77 : (items_taken < 1400 ? 29 : 0);
    endfunction

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                filter_step('{kind: s_req_type, pix: s_pixel_in});
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                    s_valid <= 1'b1;
                    s_req_type <= pixel_fifo[0].kind;
                    s_pixel_in <= pixel_fifo[0].pix;
                    void'(pixel_fifo.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (filtered_fifo.size() == 0) begin
                    report("unexpected pixel", m_pixel_out, -1);
                end else begin
                    if (m_pixel_out !== filtered_fifo[0].pix)
                        report("pixel_out", m_pixel_out, filtered_fifo[0].pix);
                    if (m_frame_last !== filtered_fifo[0].last)
                        report("frame_last", m_frame_last, filtered_fifo[0].last);
                    void'(filtered_fifo.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        if (idx == REG_IMAGE_WIDTH) cfg_w = data & 12'h7FF;
        else cfg_h = data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_sent();
        while (pixel_fifo.size() != 0 || s_valid) @(posedge aclk);
    endtask

    task automatic wait_idle();
        while (pixel_fifo.size() != 0 || s_valid || filtered_fifo.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic push_item(logic kind, logic [7:0] pix);
        pixel_fifo.push_back('{kind: kind, pix: pix});
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // queue a frame of npix pixels plus drain; noisy mixes item kinds up
    task automatic queue_frame(int unsigned w, int unsigned npix, bit noisy);
        for (int unsigned i = 0; i < npix; i++)
            push_item((noisy && $urandom_range(19) == 0) ? REQ_FLUSH : REQ_PIXEL,
                      rand_pixel());
        for (int unsigned i = 0; i < 2 * w + 2; i++)
            push_item((noisy && $urandom_range(3) == 0) ? REQ_PIXEL : REQ_FLUSH,
                      8'($urandom_range(255)));
    endtask

    // push flush items one by one until the predictor sits at a frame start
    task automatic resync_frame();
        while (frame_count != 0) begin
            push_item(REQ_FLUSH, 8'($urandom_range(255)));
            wait_sent();
        end
        wait_idle();
    endtask

    initial begin
        int unsigned w, h, w2, split;
        logic [7:0] corner_pix [0:7];
        corner_pix = '{8'd0, 8'd255, 8'h55, 8'hAA, 8'd1, 8'd254, 8'h80, 8'h7F};
        for (int i = 0; i < 4*LS_W; i++) line_rows[i] = '0;
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                window[r][c] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero sizes clamp to 5x5, extreme pixel values
        cfg_write(REG_IMAGE_WIDTH, 12'd0);
        cfg_write(REG_IMAGE_HEIGHT, 12'd0);
        for (int i = 0; i < 25; i++)
            push_item(REQ_PIXEL, corner_pix[i % 8]);
        for (int i = 0; i < 12; i++)
            push_item(REQ_FLUSH, (i % 2) ? 8'hFF : 8'h00);
        wait_idle();

        // random frames, mostly small; some get resized partway through
        while (items_taken < RAND_ITEMS - 60) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(12, 5);
            h = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(9, 5);
            cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
            cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
            w = (w < MIN_SIZE) ? MIN_SIZE : w;
            h = (h < MIN_SIZE) ? MIN_SIZE : h;
            if ($urandom_range(7) == 0) begin
                // width change in the middle of a frame
                split = $urandom_range(w * h - 1, 1);
                for (int unsigned i = 0; i < split; i++)
                    push_item(REQ_PIXEL, rand_pixel());
                wait_idle();
                w2 = $urandom_range(12, 5);
                cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w2));
                queue_frame(w2, w2 * h - (split % (w2 * h)), 1'b0);
                wait_idle();
                resync_frame();
            end else begin
                queue_frame(w, w * h, $urandom_range(4) == 0);
                wait_idle();
                if (frame_count != 0) resync_frame();
            end
        end

        // all width bits set clamps to MAX_WIDTH; cut back to 5 mid-frame
        cfg_write(REG_IMAGE_WIDTH, 12'h7FF);
        cfg_write(REG_IMAGE_HEIGHT, 12'd5);
        for (int i = 0; i < 20; i++)
            push_item(REQ_PIXEL, rand_pixel());
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, 12'd5);
        resync_frame();

        // tallest height, narrowest width; cut the height mid-frame
        cfg_write(REG_IMAGE_WIDTH, 12'd5);
        cfg_write(REG_IMAGE_HEIGHT, 12'hFFF);
        for (int i = 0; i < 40; i++)
            push_item(REQ_PIXEL, rand_pixel());
        wait_idle();
        cfg_write(REG_IMAGE_HEIGHT, 12'd5);
        resync_frame();

        if (errors == 0 && filtered_fifo.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
